[src/eau_pkg.sv]
// Package for the effective address unit: beat payload types, mode and size codes,
// and register file sizing. No dependencies.
package eau_pkg;

    localparam int RF_DEPTH = 16;          // eight data plus eight address registers
    localparam int RF_AW    = 4;

    typedef enum logic [3:0] {
        MODE_DN      = 4'd0,
        MODE_AN      = 4'd1,
        MODE_AN_IND  = 4'd2,
        MODE_POSTINC = 4'd3,
        MODE_PREDEC  = 4'd4,
        MODE_AN_D16  = 4'd5,
        MODE_AN_IDX  = 4'd6,
        MODE_ABS_W   = 4'd7,
        MODE_ABS_L   = 4'd8,
        MODE_PC_D16  = 4'd9,
        MODE_PC_IDX  = 4'd10,
        MODE_IMM     = 4'd11
    } t_ea_mode;

    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_WORD = 2'd1;
    localparam logic [1:0] SIZE_LONG = 2'd2;
    localparam logic [1:0] SIZE_RSVD = 2'd3;

    localparam logic ACT_COMPUTE = 1'b0;
    localparam logic ACT_LOAD    = 1'b1;

    // Index word layout.
    localparam int IDX_IS_ADDR_BIT = 15;
    localparam int IDX_REG_HI      = 14;
    localparam int IDX_REG_LO      = 12;
    localparam int IDX_LONG_BIT    = 11;

    localparam logic [2:0] STACK_REG = 3'd7;

    typedef struct packed {
        logic        action;
        logic [3:0]  addressing_mode;
        logic [2:0]  register_number;
        logic [1:0]  operand_size;
        logic [15:0] first_extension_word;
        logic [15:0] second_extension_word;
        logic [31:0] program_counter;
        logic [3:0]  load_select;
        logic [31:0] load_value;
    } t_eau_in;

    typedef struct packed {
        logic [31:0] effective_value;
        logic        memory_operand;
        logic        program_space;
        logic [1:0]  extension_words_used;
    } t_eau_out;

endpackage

[src/eau_in_if.sv]
// Input channel of the effective address unit: valid/ready handshake with payload.
// Depends on eau_pkg.
interface eau_in_if
    import eau_pkg::*;
;
    logic    valid;
    logic    ready;
    t_eau_in data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/eau_out_if.sv]
// Result channel of the effective address unit: valid/ready handshake with payload.
// Depends on eau_pkg.
interface eau_out_if
    import eau_pkg::*;
;
    logic     valid;
    logic     ready;
    t_eau_out data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/eau_ram.sv]
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module eau_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[src/effective_address_unit.sv]
// Effective address unit: register file plus address calculation for all twelve modes.
// A result passes through the input register, then the result register. Throughput:
// one beat per cycle while the result channel is not stalled; load beats give no result.
// Register file reads are registered at acceptance; writes land when the item leaves
// the input register. Reset is synchronous, active low, and zeroes all sixteen
// registers at once through per-entry valid bits. Depends on eau_pkg, interfaces, eau_ram.
module effective_address_unit
    import eau_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    eau_in_if.sink    i_in,
    eau_out_if.source o_out
);

    // Input stage.
    logic             r_in_valid;
    t_eau_in          r_in;
    logic             r_a_ok;
    logic             r_b_ok;
    logic             r_a_fwd;
    logic             r_b_fwd;
    logic [31:0]      r_fwd_data;

    // Result stage.
    logic             r_out_valid;
    t_eau_out         r_out;
    t_eau_out         n_out;

    logic [RF_DEPTH-1:0] r_rf_valid;

    logic             w_out_free;
    logic             w_adv;
    logic             w_acc;
    logic             w_is_load;

    logic [RF_AW-1:0] w_raddr_a;
    logic [RF_AW-1:0] w_raddr_b;
    logic [31:0]      w_q_a;
    logic [31:0]      w_q_b;

    logic             w_we;
    logic [RF_AW-1:0] w_waddr;
    logic [31:0]      w_wdata;

    logic [31:0]      w_base;
    logic [31:0]      w_xreg;
    logic [31:0]      w_index;
    logic [31:0]      w_ind_base;
    logic [31:0]      w_indexed;
    logic [31:0]      w_disp16;
    logic [31:0]      w_disp8;
    logic [31:0]      w_mask;
    logic [31:0]      w_step;
    logic [1:0]       w_size;
    logic [15:0]      w_ext1;
    logic [15:0]      w_ext2;

    // Handshake: a load leaves the input stage without needing the result slot.
    assign w_is_load  = (r_in.action == ACT_LOAD);
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_adv      = r_in_valid && (w_is_load || w_out_free);
    assign i_in.ready = !r_in_valid || w_adv;
    assign w_acc      = i_in.valid && i_in.ready;

    assign w_raddr_a = {(i_in.data.addressing_mode != MODE_DN), i_in.data.register_number};
    assign w_raddr_b = {i_in.data.first_extension_word[IDX_IS_ADDR_BIT],
                        i_in.data.first_extension_word[IDX_REG_HI:IDX_REG_LO]};

    eau_ram #(
        .WIDTH (32),
        .DEPTH (RF_DEPTH)
    ) u_rf (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_acc),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_q_a),
        .o_rdata_b (w_q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_rf_valid  <= '0;
        end else begin
            if (w_acc) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv && !w_is_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_we) begin
                r_rf_valid[w_waddr] <= 1'b1;
            end
        end
    end

    // The RAM returns old data when a write lands on the same edge as the read,
    // so that write is captured here and forwarded.
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_in       <= i_in.data;
            r_a_ok     <= r_rf_valid[w_raddr_a];
            r_b_ok     <= r_rf_valid[w_raddr_b];
            r_a_fwd    <= w_we && (w_waddr == w_raddr_a);
            r_b_fwd    <= w_we && (w_waddr == w_raddr_b);
            r_fwd_data <= w_wdata;
        end
        if (w_adv && !w_is_load) begin
            r_out <= n_out;
        end
    end

    assign w_base = r_a_fwd ? r_fwd_data : (r_a_ok ? w_q_a : 32'd0);
    assign w_xreg = r_b_fwd ? r_fwd_data : (r_b_ok ? w_q_b : 32'd0);

    assign w_ext1   = r_in.first_extension_word;
    assign w_ext2   = r_in.second_extension_word;
    assign w_size   = (r_in.operand_size == SIZE_RSVD) ? SIZE_LONG : r_in.operand_size;
    assign w_disp16 = {{16{w_ext1[15]}}, w_ext1};
    assign w_disp8  = {{24{w_ext1[7]}}, w_ext1[7:0]};
    assign w_index  = w_ext1[IDX_LONG_BIT] ? w_xreg : {{16{w_xreg[15]}}, w_xreg[15:0]};
    assign w_ind_base = (r_in.addressing_mode == MODE_PC_IDX) ? r_in.program_counter : w_base;
    assign w_indexed  = w_ind_base + w_index + w_disp8;

    always_comb begin
        case (w_size)
            SIZE_BYTE: begin
                w_mask = 32'h0000_00ff;
                // The stack pointer stays word aligned on byte steps.
                w_step = (r_in.register_number == STACK_REG) ? 32'd2 : 32'd1;
            end
            SIZE_WORD: begin
                w_mask = 32'h0000_ffff;
                w_step = 32'd2;
            end
            default: begin
                w_mask = 32'hffff_ffff;
                w_step = 32'd4;
            end
        endcase
    end

    // Register file write port: load beats and the auto-increment/decrement modes.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_in.load_select;
        w_wdata = r_in.load_value;
        if (w_adv) begin
            if (w_is_load) begin
                w_we = 1'b1;
            end else if (r_in.addressing_mode == MODE_POSTINC) begin
                w_we    = 1'b1;
                w_waddr = {1'b1, r_in.register_number};
                w_wdata = w_base + w_step;
            end else if (r_in.addressing_mode == MODE_PREDEC) begin
                w_we    = 1'b1;
                w_waddr = {1'b1, r_in.register_number};
                w_wdata = w_base - w_step;
            end
        end
    end

    always_comb begin
        n_out = '0;
        case (r_in.addressing_mode)
            MODE_DN, MODE_AN: begin
                n_out.effective_value = w_base & w_mask;
            end
            MODE_AN_IND, MODE_POSTINC: begin
                n_out.effective_value = w_base;
                n_out.memory_operand  = 1'b1;
            end
            MODE_PREDEC: begin
                n_out.effective_value = w_base - w_step;
                n_out.memory_operand  = 1'b1;
            end
            MODE_AN_D16: begin
                n_out.effective_value      = w_base + w_disp16;
                n_out.memory_operand       = 1'b1;
                n_out.extension_words_used = 2'd1;
            end
            MODE_AN_IDX: begin
                n_out.effective_value      = w_indexed;
                n_out.memory_operand       = 1'b1;
                n_out.extension_words_used = 2'd1;
            end
            MODE_ABS_W: begin
                n_out.effective_value      = w_disp16;
                n_out.memory_operand       = 1'b1;
                n_out.extension_words_used = 2'd1;
            end
            MODE_ABS_L: begin
                n_out.effective_value      = {w_ext1, w_ext2};
                n_out.memory_operand       = 1'b1;
                n_out.extension_words_used = 2'd2;
            end
            MODE_PC_D16: begin
                n_out.effective_value      = r_in.program_counter + w_disp16;
                n_out.memory_operand       = 1'b1;
                n_out.program_space        = 1'b1;
                n_out.extension_words_used = 2'd1;
            end
            MODE_PC_IDX: begin
                n_out.effective_value      = w_indexed;
                n_out.memory_operand       = 1'b1;
                n_out.program_space        = 1'b1;
                n_out.extension_words_used = 2'd1;
            end
            MODE_IMM: begin
                if (w_size == SIZE_LONG) begin
                    n_out.effective_value      = {w_ext1, w_ext2};
                    n_out.extension_words_used = 2'd2;
                end else begin
                    n_out.effective_value      = {16'd0, w_ext1} & w_mask;
                    n_out.extension_words_used = 2'd1;
                end
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

`ifndef SYNTH
    // A load beat never fills an empty result slot.
    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && w_is_load && !r_out_valid |=> !r_out_valid)
        else $error("load beat produced a result");

    // The register file is written only by an item leaving the input stage.
    a_write_from_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> r_in_valid && w_adv)
        else $error("register file written without an advancing item");

    // Program space results are always memory operands.
    a_prog_is_mem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.program_space |-> r_out.memory_operand)
        else $error("program space result without memory operand");

    // A beat taken while the input stage is full means the old item moved on.
    a_accept_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && r_in_valid |-> w_adv)
        else $error("input stage overwritten");

    // Extension word count never exceeds two.
    a_ext_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out.extension_words_used != 2'd3)
        else $error("extension word count out of range");
`endif

endmodule

[tb/effective_address_unit_tb.sv]
// Self-checking bench for effective_address_unit: directed addressing-mode beats, then
// random traffic with stalls on both channels, checked against an in-bench predictor.
// Depends on eau_pkg, eau_in_if, eau_out_if and the unit itself.
module effective_address_unit_tb;
    import eau_pkg::*;

    localparam int IDLE_PERCENT    = 36;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int STALL_LIMIT     = 2000;
    localparam int TAIL_CYCLES     = 8;

    localparam logic [3:0] MODE_RSVD_FIRST = 4'd12;
    localparam logic [3:0] MODE_RSVD_LAST  = 4'd15;
    localparam bit DATA_REG = 1'b0;
    localparam bit ADDR_REG = 1'b1;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    eau_in_if  in_ch ();
    eau_out_if out_ch ();

    effective_address_unit dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    always #5 i_clk = ~i_clk;

    // Register file mirror and expected result beats.
    logic [31:0] data_regs [8] = '{default: '0};
    logic [31:0] addr_regs [8] = '{default: '0};
    t_eau_out    pending_results [$];

    int          errors          = 0;
    int          results_checked = 0;
    int          loads_sent      = 0;
    int          computes_sent   = 0;
    int          stall_count     = 0;
    int          hold_left       = 0;
    logic [15:0] modes_seen      = '0;
    bit          steady          = 1'b0;
    bit          hold_off_pending = 1'b0;

    function automatic logic [31:0] sx16(logic [15:0] v);
        return {{16{v[15]}}, v};
    endfunction

    function automatic logic [31:0] sx8(logic [7:0] v);
        return {{24{v[7]}}, v};
    endfunction

    function automatic logic [31:0] size_mask(logic [1:0] sz);
        if (sz == SIZE_BYTE) return 32'h0000_00FF;
        if (sz == SIZE_WORD) return 32'h0000_FFFF;
        return 32'hFFFF_FFFF;
    endfunction

    // The stack pointer always moves by an even amount, so a byte step on it is two.
    function automatic logic [31:0] step_size(logic [1:0] sz, logic [2:0] rn);
        if (sz == SIZE_BYTE) return (rn == STACK_REG) ? 32'd2 : 32'd1;
        if (sz == SIZE_WORD) return 32'd2;
        return 32'd4;
    endfunction

    function automatic logic [31:0] index_sum(logic [31:0] base, logic [15:0] ext);
        logic [2:0]  xr;
        logic [31:0] x;
        xr = ext[IDX_REG_HI:IDX_REG_LO];
        x  = ext[IDX_IS_ADDR_BIT] ? addr_regs[xr] : data_regs[xr];
        if (!ext[IDX_LONG_BIT]) x = sx16(x[15:0]);
        return base + x + sx8(ext[7:0]);
    endfunction

    // Applies one beat to the mirror; returns 1 when the beat yields a result.
    function automatic bit predict_ea(input t_eau_in item, output t_eau_out res);
        logic [1:0]  sz;
        logic [2:0]  rn;
        logic [31:0] an;
        res = '0;
        if (item.action == ACT_LOAD) begin
            if (item.load_select[3]) addr_regs[item.load_select[2:0]] = item.load_value;
            else data_regs[item.load_select[2:0]] = item.load_value;
            return 1'b0;
        end
        sz = (item.operand_size == SIZE_RSVD) ? SIZE_LONG : item.operand_size;
        rn = item.register_number;
        an = addr_regs[rn];
        case (item.addressing_mode)
            MODE_DN: res.effective_value = data_regs[rn] & size_mask(sz);
            MODE_AN: res.effective_value = an & size_mask(sz);
            MODE_AN_IND: begin
                res.effective_value = an;
                res.memory_operand  = 1'b1;
            end
            MODE_POSTINC: begin
                res.effective_value = an;
                res.memory_operand  = 1'b1;
                addr_regs[rn] = an + step_size(sz, rn);
            end
            MODE_PREDEC: begin
                res.effective_value = an - step_size(sz, rn);
                res.memory_operand  = 1'b1;
                addr_regs[rn] = res.effective_value;
            end
            MODE_AN_D16: begin
                res.effective_value      = an + sx16(item.first_extension_word);
                res.memory_operand       = 1'b1;
                res.extension_words_used = 2'd1;
            end
            MODE_AN_IDX: begin
                res.effective_value      = index_sum(an, item.first_extension_word);
                res.memory_operand       = 1'b1;
                res.extension_words_used = 2'd1;
            end
            MODE_ABS_W: begin
                res.effective_value      = sx16(item.first_extension_word);
                res.memory_operand       = 1'b1;
                res.extension_words_used = 2'd1;
            end
            MODE_ABS_L: begin
                res.effective_value      = {item.first_extension_word,
                                            item.second_extension_word};
                res.memory_operand       = 1'b1;
                res.extension_words_used = 2'd2;
            end
            MODE_PC_D16: begin
                res.effective_value      = item.program_counter +
                                           sx16(item.first_extension_word);
                res.memory_operand       = 1'b1;
                res.program_space        = 1'b1;
                res.extension_words_used = 2'd1;
            end
            MODE_PC_IDX: begin
                res.effective_value      = index_sum(item.program_counter,
                                                     item.first_extension_word);
                res.memory_operand       = 1'b1;
                res.program_space        = 1'b1;
                res.extension_words_used = 2'd1;
            end
            MODE_IMM: begin
                if (sz == SIZE_BYTE) begin
                    res.effective_value      = {24'b0, item.first_extension_word[7:0]};
                    res.extension_words_used = 2'd1;
                end else if (sz == SIZE_WORD) begin
                    res.effective_value      = {16'b0, item.first_extension_word};
                    res.extension_words_used = 2'd1;
                end else begin
                    res.effective_value      = {item.first_extension_word,
                                                item.second_extension_word};
                    res.extension_words_used = 2'd2;
                end
            end
            default: ;
        endcase
        return 1'b1;
    endfunction

    function automatic t_eau_in random_item();
        t_eau_in item;
        item.action = ($urandom_range(99) < 25) ? ACT_LOAD : ACT_COMPUTE;
        if ($urandom_range(99) < 8)
            item.addressing_mode = 4'($urandom_range(int'(MODE_RSVD_LAST),
                                                     int'(MODE_RSVD_FIRST)));
        else
            item.addressing_mode = 4'($urandom_range(int'(MODE_IMM)));
        item.register_number       = 3'($urandom);
        item.operand_size          = 2'($urandom);
        item.first_extension_word  = 16'($urandom);
        item.second_extension_word = 16'($urandom);
        item.program_counter       = $urandom;
        item.load_select           = 4'($urandom);
        // Bias loads toward values where sign extension and wrap-around matter.
        case ($urandom_range(5))
            0: item.load_value = 32'h0000_0000;
            1: item.load_value = 32'hFFFF_FFFF;
            2: item.load_value = 32'h8000_0000;
            3: item.load_value = 32'h7FFF_FFFF;
            4: item.load_value = $urandom_range(16);
            default: item.load_value = $urandom;
        endcase
        return item;
    endfunction

    function automatic t_eau_in load_item(bit to_addr, logic [2:0] rn, logic [31:0] val);
        t_eau_in item;
        item             = random_item();
        item.action      = ACT_LOAD;
        item.load_select = {to_addr, rn};
        item.load_value  = val;
        return item;
    endfunction

    function automatic t_eau_in ea_item(logic [3:0] mode, logic [2:0] rn, logic [1:0] sz,
                                        logic [15:0] ext1, logic [15:0] ext2,
                                        logic [31:0] pc);
        t_eau_in item;
        item                       = random_item();
        item.action                = ACT_COMPUTE;
        item.addressing_mode       = mode;
        item.register_number       = rn;
        item.operand_size          = sz;
        item.first_extension_word  = ext1;
        item.second_extension_word = ext2;
        item.program_counter       = pc;
        return item;
    endfunction

    function automatic logic [15:0] index_word(bit is_addr, logic [2:0] rn, bit is_long,
                                               logic [7:0] disp);
        return {is_addr, rn, is_long, 3'b000, disp};
    endfunction

    // Valid stays high from one beat to the next unless an idle cycle is drawn.
    task automatic send_beat(input t_eau_in item);
        t_eau_out res;
        while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (predict_ea(item, res)) begin
            pending_results.push_back(res);
            computes_sent++;
            modes_seen[item.addressing_mode] = 1'b1;
        end else begin
            loads_sent++;
        end
    endtask

    task automatic await_drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic send_random(input int count);
        repeat (count) send_beat(random_item());
    endtask

    task automatic test_register_loads();
        send_beat(load_item(DATA_REG, 3'd0, 32'hFFFF_FFFF));
        send_beat(load_item(DATA_REG, 3'd3, 32'h0000_8080));
        send_beat(load_item(ADDR_REG, STACK_REG, 32'h0000_1000));
        send_beat(load_item(ADDR_REG, 3'd5, 32'h7FFF_FFFE));
        send_beat(ea_item(MODE_DN, 3'd0, SIZE_BYTE, 16'h0000, 16'h0000, 32'h0));
        send_beat(ea_item(MODE_DN, 3'd3, SIZE_WORD, 16'hFFFF, 16'hFFFF, 32'h0));
        send_beat(ea_item(MODE_DN, 3'd1, SIZE_LONG, 16'h0000, 16'h0000, 32'h0));
        send_beat(ea_item(MODE_AN, 3'd5, SIZE_LONG, 16'h0000, 16'h0000, 32'h0));
    endtask

    task automatic test_addressing_modes();
        send_beat(ea_item(MODE_AN_IND, STACK_REG, SIZE_LONG, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_POSTINC, 3'd5, SIZE_LONG, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_PREDEC, 3'd0, SIZE_WORD, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_AN_D16, 3'd5, SIZE_WORD, 16'h8000, 16'h0, 32'h0));
        send_beat(ea_item(MODE_AN_IDX, STACK_REG, SIZE_BYTE,
                          index_word(DATA_REG, 3'd3, 1'b0, 8'h80), 16'h0, 32'h0));
        send_beat(ea_item(MODE_AN_IDX, STACK_REG, SIZE_LONG,
                          index_word(ADDR_REG, 3'd5, 1'b1, 8'h7F), 16'h0, 32'h0));
        send_beat(ea_item(MODE_ABS_W, 3'd0, SIZE_WORD, 16'hFFFF, 16'h0, 32'h0));
        send_beat(ea_item(MODE_ABS_L, 3'd0, SIZE_LONG, 16'hFFFF, 16'h0001, 32'h0));
        send_beat(ea_item(MODE_PC_D16, 3'd0, SIZE_WORD, 16'h7FFF, 16'h0, 32'hFFFF_FFFE));
        send_beat(ea_item(MODE_PC_IDX, 3'd0, SIZE_WORD,
                          index_word(DATA_REG, 3'd0, 1'b1, 8'hFF), 16'h0, 32'h0));
        send_beat(ea_item(MODE_IMM, 3'd0, SIZE_BYTE, 16'hABCD, 16'h1234, 32'h0));
        send_beat(ea_item(MODE_IMM, 3'd0, SIZE_WORD, 16'hABCD, 16'h1234, 32'h0));
        send_beat(ea_item(MODE_IMM, 3'd0, SIZE_LONG, 16'hABCD, 16'h1234, 32'h0));
    endtask

    task automatic test_stack_byte_step();
        send_beat(ea_item(MODE_POSTINC, STACK_REG, SIZE_BYTE, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_PREDEC, STACK_REG, SIZE_BYTE, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_POSTINC, 3'd6, SIZE_BYTE, 16'h0, 16'h0, 32'h0));
    endtask

    // The reserved size code behaves as long; unused mode codes give an all-zero result.
    task automatic test_reserved_codes();
        send_beat(ea_item(MODE_PREDEC, 3'd5, SIZE_RSVD, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_DN, 3'd0, SIZE_RSVD, 16'h0, 16'h0, 32'h0));
        send_beat(ea_item(MODE_RSVD_FIRST, 3'd5, SIZE_WORD, 16'hFFFF, 16'hFFFF,
                          32'hFFFF_FFFF));
        send_beat(ea_item(MODE_RSVD_LAST, STACK_REG, SIZE_BYTE, 16'hFFFF, 16'hFFFF,
                          32'hFFFF_FFFF));
    endtask

    task automatic test_random_traffic();
        send_random(250);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        send_random(130);
        steady = 1'b0;
    endtask

    // The result side stops for a long stretch while beats keep coming, so the
    // pipeline fills and input ready has to drop.
    task automatic test_output_hold_off();
        steady           = 1'b1;
        hold_off_pending = 1'b1;
        send_random(60);
        steady = 1'b0;
    endtask

    task automatic test_drain_pause();
        repeat (6) begin
            send_random(15);
            await_drain();
        end
    endtask

    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left != 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (hold_off_pending) begin
                hold_off_pending = 1'b0;
                hold_left        = HOLD_OFF_CYCLES - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
            end
        end
    end

    always @(posedge i_clk) begin
        t_eau_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with none expected: effective_value %h",
                       out_ch.data.effective_value);
                errors++;
            end else begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_ch.data.effective_value !== want.effective_value) begin
                    $error("effective_value: expected %h, got %h",
                           want.effective_value, out_ch.data.effective_value);
                    errors++;
                end
                if (out_ch.data.memory_operand !== want.memory_operand) begin
                    $error("memory_operand: expected %b, got %b",
                           want.memory_operand, out_ch.data.memory_operand);
                    errors++;
                end
                if (out_ch.data.program_space !== want.program_space) begin
                    $error("program_space: expected %b, got %b",
                           want.program_space, out_ch.data.program_space);
                    errors++;
                end
                if (out_ch.data.extension_words_used !== want.extension_words_used) begin
                    $error("extension_words_used: expected %0d, got %0d",
                           want.extension_words_used, out_ch.data.extension_words_used);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                stall_count = 0;
            else
                stall_count++;
            if (stall_count >= STALL_LIMIT) begin
                $display("Timeout: no beat accepted for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_register_loads();
        test_addressing_modes();
        test_stack_byte_step();
        test_reserved_codes();
        test_random_traffic();
        test_back_to_back();
        test_output_hold_off();
        test_drain_pause();

        await_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d beats (%0d register loads, %0d address computations);",
                 loads_sent + computes_sent, loads_sent, computes_sent);
        $display("%0d results checked; mode codes exercised, one bit per code: %016b",
                 results_checked, modes_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
